@@ rtl/cds_pkg.sv @@
package cds_pkg;

	// mode codes
	localparam logic [2:0] MODE_DAYS        = 3'd0;
	localparam logic [2:0] MODE_WEEKS       = 3'd1;
	localparam logic [2:0] MODE_MONTH_STEP  = 3'd2;
	localparam logic [2:0] MODE_YEAR_STEP   = 3'd3;
	localparam logic [2:0] MODE_YEARS       = 3'd4;
	localparam logic [2:0] MODE_DECADES     = 3'd5;
	localparam logic [2:0] MODE_CENTURIES   = 3'd6;
	localparam logic [2:0] MODE_DECADE_STEP = 3'd7;

	localparam logic [3:0] JANUARY  = 4'd1;
	localparam logic [3:0] FEBRUARY = 4'd2;
	localparam logic [3:0] DECEMBER = 4'd12;

	localparam logic [6:0] DAYS_PER_WEEK     = 7'd7;
	localparam logic [6:0] YEARS_PER_DECADE  = 7'd10;
	localparam logic [6:0] YEARS_PER_CENTURY = 7'd100;

	typedef struct packed {
		logic [2:0]         mode;
		logic [13:0]        amount;
		logic [4:0]         day_in;
		logic [3:0]         month_in;
		logic signed [15:0] year_in;
	} cds_req_t;

	typedef struct packed {
		logic [4:0]         day_out;
		logic [3:0]         month_out;
		logic signed [15:0] year_out;
	} cds_rsp_t;

	// Remainder of a 16-bit unsigned value by 25 (256 = 6 and 32 = 7 modulo 25)
	function automatic logic [4:0] mod25(input logic [15:0] x);
		logic [10:0] v1;
		logic [8:0]  v2;
		logic [6:0]  v3;
		logic [6:0]  r;
		v1 = 11'({x[15:8], 2'b00}) + 11'({x[15:8], 1'b0}) + 11'(x[7:0]);
		v2 = 9'({v1[10:5], 3'b000}) - 9'(v1[10:5]) + 9'(v1[4:0]);
		v3 = 7'({v2[8:5], 3'b000}) - 7'(v2[8:5]) + 7'(v2[4:0]);
		if (v3 >= 7'd100) begin
			r = v3 - 7'd100;
		end else if (v3 >= 7'd75) begin
			r = v3 - 7'd75;
		end else if (v3 >= 7'd50) begin
			r = v3 - 7'd50;
		end else if (v3 >= 7'd25) begin
			r = v3 - 7'd25;
		end else begin
			r = v3;
		end
		return r[4:0];
	endfunction

	// Gregorian leap test on the signed year; 2^16 = 11 modulo 25
	function automatic logic is_leap(input logic [15:0] y);
		logic [4:0] r;
		logic       div4;
		logic       div16;
		logic       div25;
		r     = mod25(y);
		div4  = (y[1:0] == 2'b00);
		div16 = (y[3:0] == 4'b0000);
		div25 = y[15] ? (r == 5'd11) : (r == 5'd0);
		return (div16 && div25) || (div4 && !div25);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/cds_stream_if.sv @@
interface cds_stream_if #(
	parameter type payload_t = cds_pkg::cds_req_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/calendar_date_subtract.sv @@
// Flow: an accepted beat passes through CLAMP and RUN to DONE, where the result is loaded;
// modes 4..6 with a nonzero count add another CLAMP/RUN pass, the month, year and decade
// step modes a CLAMP/RUN pass per step, and days and weeks a FILL/RUN pass per month crossed.
// Throughput: one item at a time, set by the single month-length/clamp unit and step counter;
// the next beat is accepted in the cycle after the result is loaded, even while a result waits.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops any held result.
module calendar_date_subtract (
	input logic         clk,
	input logic         arst_n,
	cds_stream_if.sink   req,
	cds_stream_if.source rsp
);
	import cds_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLAMP = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_FILL  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [2:0]  mode_q;
	logic [16:0] n_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [15:0] y_q;
	cds_rsp_t    out_q;
	logic        out_valid_q;

	logic        leap;
	logic [4:0]  mlen;
	logic [6:0]  mul_k;
	logic [16:0] prod;
	logic [3:0]  m_fix;
	logic [4:0]  d_fix;
	logic        day_mode;
	logic        step_mode;
	logic        n_zero;
	logic        n_below_d;
	logic        out_free;
	logic [3:0]  m_prev;
	logic [15:0] y_prev;

	// Shared month-length unit on the current date
	assign leap = is_leap(y_q);
	assign mlen = month_days(m_q, leap);

	// Scale the count at load time; only the low 16 bits matter for whole-count modes
	always_comb begin
		case (req.data.mode)
			MODE_WEEKS:     mul_k = DAYS_PER_WEEK;
			MODE_DECADES:   mul_k = YEARS_PER_DECADE;
			MODE_CENTURIES: mul_k = YEARS_PER_CENTURY;
			default:        mul_k = 7'd1;
		endcase
	end
	assign prod = 17'(req.data.amount) * 17'(mul_k);

	// Correct out-of-range month and zero day
	always_comb begin
		if (req.data.month_in < JANUARY) begin
			m_fix = JANUARY;
		end else if (req.data.month_in > DECEMBER) begin
			m_fix = DECEMBER;
		end else begin
			m_fix = req.data.month_in;
		end
		d_fix = (req.data.day_in == 5'd0) ? 5'd1 : req.data.day_in;
	end

	assign day_mode  = (mode_q == MODE_DAYS) || (mode_q == MODE_WEEKS);
	assign step_mode = (mode_q == MODE_MONTH_STEP) || (mode_q == MODE_YEAR_STEP)
		|| (mode_q == MODE_DECADE_STEP);
	assign n_zero    = (n_q == 17'd0);
	assign n_below_d = (n_q < 17'(d_q));
	assign out_free  = !out_valid_q || rsp.ready;

	// Previous month with year borrow
	always_comb begin
		if (m_q == JANUARY) begin
			m_prev = DECEMBER;
			y_prev = y_q - 16'd1;
		end else begin
			m_prev = m_q - 4'd1;
			y_prev = y_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (n_zero) begin
						state_q <= ST_DONE;
					end else if (day_mode) begin
						state_q <= n_below_d ? ST_DONE : ST_FILL;
					end else begin
						state_q <= ST_CLAMP;
					end
				end
				ST_FILL: begin
					state_q <= ST_RUN;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Date and count registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					mode_q <= req.data.mode;
					n_q    <= prod;
					d_q    <= d_fix;
					m_q    <= m_fix;
					y_q    <= req.data.year_in;
				end
			end
			ST_CLAMP: begin
				if (d_q > mlen) begin
					d_q <= mlen;
				end
			end
			ST_RUN: begin
				if (!n_zero) begin
					if (day_mode) begin
						// consume the whole month or finish inside it
						if (n_below_d) begin
							d_q <= d_q - n_q[4:0];
							n_q <= 17'd0;
						end else begin
							n_q <= n_q - 17'(d_q);
							m_q <= m_prev;
							y_q <= y_prev;
						end
					end else if (step_mode) begin
						n_q <= n_q - 17'd1;
						if (mode_q == MODE_MONTH_STEP) begin
							m_q <= m_prev;
							y_q <= y_prev;
						end else if (mode_q == MODE_DECADE_STEP) begin
							y_q <= y_q - 16'(YEARS_PER_DECADE);
						end else begin
							y_q <= y_q - 16'd1;
						end
					end else begin
						// whole-count subtract, modulo 2^16
						y_q <= y_q - n_q[15:0];
						n_q <= 17'd0;
					end
				end
			end
			ST_FILL: begin
				d_q <= mlen;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.day_out   <= d_q;
					out_q.month_out <= m_q;
					out_q.year_out  <= y_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ tb/tb_calendar_date_subtract.sv @@
`timescale 1ns / 1ps

module tb_calendar_date_subtract;
	import cds_pkg::*;

	localparam int          RANDOM_ITEMS = 880;
	localparam int          GAP_MAX      = 20;
	localparam int          HOLD_CYCLES  = 600;
	localparam int          TAIL_CYCLES  = 50;
	localparam int unsigned MONTH_MIN    = 28;

	localparam logic [4:0] MONTH_LEN [1:12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic signed [15:0] EDGE_YEARS [8] = '{
		16'sd0, -16'sd4, -16'sd100, -16'sd400, 16'sd1900, 16'sd2000, 16'sh8000, 16'sh7FFF
	};

	logic clk = 1'b0;
	logic arst_n;

	cds_stream_if #(.payload_t(cds_req_t)) req_if ();
	cds_stream_if #(.payload_t(cds_rsp_t)) rsp_if ();

	calendar_date_subtract DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cds_req_t    date_q [$];
	cds_rsp_t    want_q [$];
	int          mismatches = 0;
	int          picked = 0;
	int          seen = 0;
	int          n_directed = 0;
	int unsigned cycles = 0;
	int unsigned limit_cycles = 0;
	int unsigned work_cycles = 0;

	// clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic logic leap_year(input logic signed [15:0] y);
		int s;
		s = y;
		return (s % 400 == 0) || ((s % 4 == 0) && (s % 100 != 0));
	endfunction

	function automatic logic [4:0] days_of(input logic [3:0] m, input logic signed [15:0] y);
		if (m == FEBRUARY && leap_year(y)) begin
			return 5'd29;
		end
		return MONTH_LEN[m];
	endfunction

	// compute the date moved back by the requested count
	function automatic cds_rsp_t predict_date(input cds_req_t r);
		logic [4:0]         d;
		logic [3:0]         m;
		logic signed [15:0] y;
		int unsigned        amt;
		int unsigned        n;
		int unsigned        mul;
		cds_rsp_t           o;
		amt = r.amount;
		y   = r.year_in;
		m   = r.month_in;
		if (m < JANUARY) m = JANUARY;
		if (m > DECEMBER) m = DECEMBER;
		d = r.day_in;
		if (d == 5'd0) d = 5'd1;
		if (d > days_of(m, y)) d = days_of(m, y);
		case (r.mode)
			MODE_DAYS, MODE_WEEKS: begin
				n = (r.mode == MODE_WEEKS) ? amt * DAYS_PER_WEEK : amt;
				for (int unsigned i = 0; i < n; i++) begin
					if (d > 5'd1) begin
						d = d - 5'd1;
					end else begin
						if (m == JANUARY) begin
							m = DECEMBER;
							y = y - 16'sd1;
						end else begin
							m = m - 4'd1;
						end
						d = days_of(m, y);
					end
				end
			end
			MODE_MONTH_STEP: begin
				for (int unsigned i = 0; i < amt; i++) begin
					if (m == JANUARY) begin
						m = DECEMBER;
						y = y - 16'sd1;
					end else begin
						m = m - 4'd1;
					end
					if (d > days_of(m, y)) d = days_of(m, y);
				end
			end
			MODE_YEAR_STEP, MODE_DECADE_STEP: begin
				n = (r.mode == MODE_DECADE_STEP) ? YEARS_PER_DECADE : 1;
				for (int unsigned i = 0; i < amt; i++) begin
					y = y - 16'(n);
					if (d > days_of(m, y)) d = days_of(m, y);
				end
			end
			default: begin
				mul = (r.mode == MODE_YEARS) ? 1 :
				      (r.mode == MODE_DECADES) ? YEARS_PER_DECADE : YEARS_PER_CENTURY;
				n = amt * mul;
				y = y - 16'(n);
				if (d > days_of(m, y)) d = days_of(m, y);
			end
		endcase
		o.day_out   = d;
		o.month_out = m;
		o.year_out  = y;
		return o;
	endfunction

	// rough upper bound of the block's cycles for one item
	function automatic int unsigned cost_of(input cds_req_t r);
		int unsigned amt;
		amt = r.amount;
		case (r.mode)
			MODE_DAYS:        return 2 * (amt / MONTH_MIN + 2) + 16;
			MODE_WEEKS:       return 2 * (amt * DAYS_PER_WEEK / MONTH_MIN + 2) + 16;
			MODE_MONTH_STEP,
			MODE_YEAR_STEP,
			MODE_DECADE_STEP: return 2 * amt + 16;
			default:          return 16;
		endcase
	endfunction

	function automatic cds_req_t random_date_req();
		cds_req_t r;
		r.mode = 3'($urandom_range(0, 7));
		// year: full range, common era, or near leap-rule and wrap edges
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.year_in = 16'($urandom);
			4, 5, 6:    r.year_in = 16'($urandom_range(1500, 2500));
			default:    r.year_in = EDGE_YEARS[$urandom_range(0, 7)] + 16'($urandom_range(0, 2))
			                        - 16'sd1;
		endcase
		// mostly valid dates with month ends favored, some raw fields
		if ($urandom_range(0, 6) != 0) begin
			r.month_in = 4'($urandom_range(1, 12));
			r.day_in = ($urandom_range(0, 3) == 0) ? days_of(r.month_in, r.year_in) :
			           5'($urandom_range(1, days_of(r.month_in, r.year_in)));
		end else begin
			r.month_in = 4'($urandom_range(0, 15));
			r.day_in   = 5'($urandom_range(0, 31));
		end
		// keep stepwise counts mostly small, since the block works through them one step at a time
		case (r.mode)
			MODE_MONTH_STEP, MODE_YEAR_STEP, MODE_DECADE_STEP:
				r.amount = ($urandom_range(0, 29) == 0) ? 14'($urandom_range(0, 16383)) :
				           14'($urandom_range(0, 40));
			MODE_WEEKS:
				r.amount = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 16383)) :
				           14'($urandom_range(0, 600));
			default:
				r.amount = ($urandom_range(0, 2) == 0) ? 14'($urandom_range(0, 60)) :
				           14'($urandom_range(0, 16383));
		endcase
		return r;
	endfunction

	task automatic add_req(input cds_req_t r);
		date_q.push_back(r);
		work_cycles += cost_of(r);
	endtask

	task automatic add_date(input logic [2:0] mode, input int amount, input int day,
	                        input int month, input int year);
		cds_req_t r;
		r.mode     = mode;
		r.amount   = 14'(amount);
		r.day_in   = 5'(day);
		r.month_in = 4'(month);
		r.year_in  = 16'(year);
		add_req(r);
	endtask

	// sender: bursts of beats separated by random gaps, fed from date_q
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!req_if.valid || req_if.ready) begin
			// log the beat just taken
			if (req_if.valid) begin
				want_q.push_back(predict_date(req_if.data));
			end
			if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (date_q.size() == 0 ||
			             ((picked == n_directed || picked == n_directed + 450) &&
			              want_q.size() != 0)) begin
				// out of items, or pausing until every result is back
				req_if.valid <= 1'b0;
			end else begin
				req_if.valid <= 1'b1;
				req_if.data  <= date_q.pop_front();
				picked++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
				end
			end
		end
	end

	// receiver: check each beat, stall on a rotating mask, one long hold-off
	logic [7:0] stall_mask;
	int         pat_pos;
	int         hold_left;
	logic       hold_done;
	cds_rsp_t   want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_mask = 8'hFF;
			pat_pos    = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				seen++;
				if (want_q.size() == 0) begin
					$display("%0t unexpected result: got %0d/%0d/%0d", $time,
					         rsp_if.data.day_out, rsp_if.data.month_out, rsp_if.data.year_out);
					mismatches++;
				end else begin
					want = want_q.pop_front();
					if (rsp_if.data.day_out !== want.day_out) begin
						$display("%0t day_out mismatch: expected %0d, got %0d", $time,
						         want.day_out, rsp_if.data.day_out);
						mismatches++;
					end
					if (rsp_if.data.month_out !== want.month_out) begin
						$display("%0t month_out mismatch: expected %0d, got %0d", $time,
						         want.month_out, rsp_if.data.month_out);
						mismatches++;
					end
					if (rsp_if.data.year_out !== want.year_out) begin
						$display("%0t year_out mismatch: expected %0d, got %0d", $time,
						         want.year_out, rsp_if.data.year_out);
						mismatches++;
					end
				end
			end
			// start the long hold-off once, well into the random part
			if (!hold_done && seen >= n_directed + 100) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			// pick a new mask now and then, sometimes no stalls at all
			pat_pos++;
			if (pat_pos % 300 == 0) begin
				stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= stall_mask[pat_pos % 8];
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;

		// directed: field extremes, every mode, each correction and wrap
		add_date(MODE_DAYS, 0, 31, 12, 32767);
		add_date(MODE_DAYS, 1, 1, 1, -32768);
		add_date(MODE_DAYS, 0, 0, 0, 0);
		add_date(MODE_DAYS, 0, 31, 15, -1);
		add_date(MODE_DAYS, 0, 31, 2, 2000);
		add_date(MODE_DAYS, 0, 30, 2, 1900);
		add_date(MODE_DAYS, 1, 1, 3, 0);
		add_date(MODE_DAYS, 1, 1, 3, -4);
		add_date(MODE_DAYS, 16383, 31, 12, 32767);
		add_date(MODE_WEEKS, 52, 15, 6, 2024);
		add_date(MODE_WEEKS, 16383, 1, 1, 0);
		add_date(MODE_MONTH_STEP, 1, 31, 3, 2023);
		add_date(MODE_MONTH_STEP, 13, 31, 1, 2024);
		add_date(MODE_MONTH_STEP, 16383, 31, 12, -32768);
		add_date(MODE_YEAR_STEP, 1, 29, 2, 2024);
		add_date(MODE_YEAR_STEP, 1, 15, 7, -32768);
		add_date(MODE_YEAR_STEP, 16383, 29, 2, 32767);
		add_date(MODE_YEARS, 4, 29, 2, 2024);
		add_date(MODE_YEARS, 16383, 31, 1, 0);
		add_date(MODE_DECADES, 16383, 29, 2, 2000);
		add_date(MODE_CENTURIES, 9999, 29, 2, 2000);
		add_date(MODE_CENTURIES, 16383, 0, 13, 100);
		add_date(MODE_DECADE_STEP, 3, 29, 2, 2000);
		add_date(MODE_DECADE_STEP, 16383, 31, 10, -32768);
		n_directed = date_q.size();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			add_req(random_date_req());
		end

		// generous bound: block work, every gap and stall, the hold-off
		limit_cycles = 4 * (work_cycles + date_q.size() * (GAP_MAX + 24) + HOLD_CYCLES)
		               + 20000;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// check on the falling edge so the sender's updates have settled
		while (date_q.size() != 0 || req_if.valid || want_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		wait (limit_cycles != 0);
		while (cycles < limit_cycles) begin
			@(posedge clk);
		end
		$display("timeout after %0d cycles", cycles);
		$display("FAIL");
		$finish;
	end

endmodule
